[design/mvms_pkg.sv]
// Shared types, codes and sizing constants for the MaxSim scorer.
package mvms_pkg;

	localparam int DEF_MAX_DIM          = 128;
	localparam int DEF_MAX_QUERY_TOKENS = 32;
	localparam int VALUE_BITS           = 16;
	localparam int PROD_W               = 2 * VALUE_BITS;
	localparam int ACC_W                = 39;
	localparam int SCORE_W              = 48;
	localparam int DIM_W                = 8;
	localparam int COUNT_W              = 6;
	localparam int ERR_W                = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DOC  = 1'b1;

	localparam logic CFG_VEC_DIM     = 1'b0;
	localparam logic CFG_QUERY_COUNT = 1'b1;

	localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
	localparam logic [ERR_W-1:0] ERR_MID_TOKEN  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 2'd2;

	typedef struct packed {
		logic                         cmd;
		logic signed [VALUE_BITS-1:0] elem_value;
		logic                         last;
	} in_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [ERR_W-1:0]          error_code;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic elem;
		logic issue;
		logic sum_step;
		logic sum_first;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
	} dp_status_t;

endpackage

[design/mvms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mvms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/mvms_ctrl.sv]
// Sequencer: accepts beats, walks the query tokens, then the final sum.
module mvms_ctrl #(
	parameter int MAX_QUERY_TOKENS = mvms_pkg::DEF_MAX_QUERY_TOKENS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_cmd,
	output logic                                  in_ready,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [mvms_pkg::COUNT_W-1:0]          qc,
	input  mvms_pkg::dp_status_t                  st,
	output mvms_pkg::ctrl_cmd_t                   cmd,
	output logic [((MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1) + 1 > 6 ?
		(MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1) + 1 : 6)-1:0] cnt
);

	localparam int QI_W  = MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1;
	localparam int CNT_W = QI_W + 1 > 6 ? QI_W + 1 : 6;

	mvms_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             cnt_end;

	assign cnt_end = (cnt_q == CNT_W'(qc - 6'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvms_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			mvms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == mvms_pkg::CMD_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.elem = 1'b1;
						cnt_d    = '0;
						state_d  = mvms_pkg::ST_MAC;
					end
				end
			end
			mvms_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_end) begin
					state_d = mvms_pkg::ST_DRAIN;
				end
			end
			mvms_pkg::ST_DRAIN: begin
				if (!st.busy) begin
					cnt_d   = '0;
					state_d = st.last ? mvms_pkg::ST_SUM : mvms_pkg::ST_IDLE;
				end
			end
			mvms_pkg::ST_SUM: begin
				cmd.sum_step  = 1'b1;
				cmd.sum_first = (cnt_q == '0);
				cnt_d         = cnt_q + 1'b1;
				if (cnt_end) begin
					state_d = mvms_pkg::ST_FIN;
				end
			end
			mvms_pkg::ST_FIN: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = mvms_pkg::ST_IDLE;
				end
			end
			default: state_d = mvms_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign cnt       = cnt_q;

endmodule

[design/mvms_dp.sv]
// Datapath: query store, shared MAC, per-token sums and bests, score.
module mvms_dp #(
	parameter int MAX_DIM          = mvms_pkg::DEF_MAX_DIM,
	parameter int MAX_QUERY_TOKENS = mvms_pkg::DEF_MAX_QUERY_TOKENS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mvms_pkg::ctrl_cmd_t          cmd,
	input  logic [((MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1) + 1 > 6 ?
		(MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1) + 1 : 6)-1:0] cnt,
	input  logic [mvms_pkg::DIM_W-1:0]   dim,
	input  logic [mvms_pkg::COUNT_W-1:0] qc,
	input  mvms_pkg::in_item_t           in_data,
	output mvms_pkg::dp_status_t         st,
	output mvms_pkg::out_item_t          out_data
);

	localparam int QI_W    = MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1;
	localparam int DEPTH   = MAX_DIM * MAX_QUERY_TOKENS;
	localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int BASE_W  = (ADDR_W > 14 ? ADDR_W : 14) + 1;
	localparam int CMP_W   = FILL_W > 14 ? FILL_W : 14;
	localparam int VB      = mvms_pkg::VALUE_BITS;
	localparam int PW      = mvms_pkg::PROD_W;
	localparam int AW      = mvms_pkg::ACC_W;
	localparam int SW      = mvms_pkg::SCORE_W;
	localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [SW-1:0] SC_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] SC_MAX  = {1'b0, {(SW-1){1'b1}}};

	logic [FILL_W-1:0]      fill_q;
	logic                   closed_q;
	logic [7:0]             elem_idx_q;
	logic                   any_q;
	logic signed [VB-1:0]   x_q;
	logic                   last_q;
	logic                   tok_q;
	logic [BASE_W-1:0]      base_q;
	logic                   v_s1, inr_s1, v_s2;
	logic [QI_W-1:0]        q_s1, q_s2;
	logic signed [PW-1:0]   prod_s2;
	logic signed [AW-1:0]   dot_q  [MAX_QUERY_TOKENS];
	logic signed [AW-1:0]   best_q [MAX_QUERY_TOKENS];
	logic signed [SW-1:0]   score_q;
	mvms_pkg::out_item_t    out_q;

	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [VB-1:0]          rd_data;
	logic [FILL_W-1:0]      fill_base;
	logic [8:0]             idx_inc;
	logic                   tok_end;
	logic signed [VB-1:0]   qv;
	logic signed [AW:0]     acc_sum;
	logic signed [AW-1:0]   acc_new;
	logic signed [SW:0]     sc_sum;
	logic signed [SW-1:0]   sc_new;
	logic [CMP_W-1:0]       need;
	logic [mvms_pkg::ERR_W-1:0] err;
	logic                   clr_doc;

	// a new load restarts at entry 0 once the previous one was closed
	assign fill_base = closed_q ? '0 : fill_q;
	assign wr_en     = cmd.load && (fill_base < FILL_W'(DEPTH));
	assign wr_addr   = fill_base[ADDR_W-1:0];

	mvms_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_data.elem_value),
		.rd_en   (cmd.issue),
		.rd_addr (base_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign idx_inc = {1'b0, elem_idx_q} + 9'd1;
	assign tok_end = idx_inc >= {1'b0, dim};
	assign qv      = inr_s1 ? $signed(rd_data) : '0;

	always_comb begin
		acc_sum = {dot_q[q_s2][AW-1], dot_q[q_s2]}
			+ {{(AW + 1 - PW){prod_s2[PW-1]}}, prod_s2};
		if (acc_sum[AW] != acc_sum[AW-1]) begin
			acc_new = acc_sum[AW] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_new = acc_sum[AW-1:0];
		end
	end

	always_comb begin
		sc_sum = (cmd.sum_first ? '0 : {score_q[SW-1], score_q})
			+ {{(SW + 1 - AW){best_q[cnt[QI_W-1:0]][AW-1]}}, best_q[cnt[QI_W-1:0]]};
		if (sc_sum[SW] != sc_sum[SW-1]) begin
			sc_new = sc_sum[SW] ? SC_MIN : SC_MAX;
		end else begin
			sc_new = sc_sum[SW-1:0];
		end
	end

	always_comb begin
		need = CMP_W'(dim) * CMP_W'(qc);
		if (CMP_W'(fill_q) < need) begin
			err = mvms_pkg::ERR_INCOMPLETE;
		end else if (elem_idx_q != '0) begin
			err = mvms_pkg::ERR_MID_TOKEN;
		end else begin
			err = mvms_pkg::ERR_OK;
		end
	end

	assign clr_doc = cmd.load || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			closed_q   <= 1'b0;
			elem_idx_q <= '0;
			any_q      <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			last_q     <= 1'b0;
			for (int i = 0; i < MAX_QUERY_TOKENS; i++) begin
				dot_q[i]  <= '0;
				best_q[i] <= ACC_MIN;
			end
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.load) begin
				closed_q <= in_data.last;
				fill_q   <= wr_en ? fill_base + 1'b1 : fill_base;
			end
			if (cmd.elem) begin
				elem_idx_q <= tok_end ? '0 : idx_inc[7:0];
				any_q      <= any_q | tok_end;
				last_q     <= in_data.last;
			end
			if (v_s2) begin
				if (tok_q) begin
					if (acc_new > best_q[q_s2]) begin
						best_q[q_s2] <= acc_new;
					end
					dot_q[q_s2] <= '0;
				end else begin
					dot_q[q_s2] <= acc_new;
				end
			end
			if (clr_doc) begin
				elem_idx_q <= '0;
				any_q      <= 1'b0;
				for (int i = 0; i < MAX_QUERY_TOKENS; i++) begin
					dot_q[i]  <= '0;
					best_q[i] <= ACC_MIN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.elem) begin
			x_q    <= in_data.elem_value;
			tok_q  <= tok_end;
			base_q <= BASE_W'(elem_idx_q);
		end
		if (cmd.issue) begin
			base_q <= base_q + BASE_W'(dim);
			q_s1   <= cnt[QI_W-1:0];
			inr_s1 <= base_q < BASE_W'(DEPTH);
		end
		q_s2    <= q_s1;
		prod_s2 <= qv * x_q;
		if (cmd.sum_step) begin
			score_q <= sc_new;
		end
		if (cmd.finish) begin
			out_q.error_code <= err;
			out_q.score      <= (err == mvms_pkg::ERR_OK && any_q) ? score_q : '0;
		end
	end

	assign st.busy  = v_s1 | v_s2;
	assign st.last  = last_q;
	assign out_data = out_q;

endmodule

[design/multivector_maxsim_score.sv]
// Top level of the late-interaction MaxSim scorer.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid in_ready in_data        | one query or document element
//  out     | out_valid out_ready out_data     | one score per document
//  cfg     | cfg_we cfg_index cfg_data        | one register write
//
// A query element is taken while the sequencer is idle. After a document element,
// the single shared MAC walks the qc query tokens, then the store read and product
// stages drain; a document's last element adds a pass over the qc tokens for the
// sum. Reset leaves the store contents undefined; the fill count marks what is
// valid. A result still waiting on out_ready holds the next document's result,
// and with it the input, until the output register is free.
module multivector_maxsim_score #(
	parameter int MAX_DIM          = mvms_pkg::DEF_MAX_DIM,
	parameter int MAX_QUERY_TOKENS = mvms_pkg::DEF_MAX_QUERY_TOKENS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mvms_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mvms_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mvms_pkg::DIM_W-1:0] cfg_data
);

	localparam int QI_W  = MAX_QUERY_TOKENS > 1 ? $clog2(MAX_QUERY_TOKENS) : 1;
	localparam int CNT_W = QI_W + 1 > 6 ? QI_W + 1 : 6;

	logic [mvms_pkg::DIM_W-1:0]   vec_dim_q;
	logic [mvms_pkg::COUNT_W-1:0] query_count_q;
	logic [mvms_pkg::DIM_W-1:0]   dim;
	logic [mvms_pkg::COUNT_W-1:0] qc;
	mvms_pkg::ctrl_cmd_t          cmd;
	mvms_pkg::dp_status_t         st;
	logic [CNT_W-1:0]             cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_dim_q     <= 8'd128;
			query_count_q <= 6'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvms_pkg::CFG_VEC_DIM:     vec_dim_q     <= cfg_data;
				mvms_pkg::CFG_QUERY_COUNT: query_count_q <= cfg_data[mvms_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (vec_dim_q == '0) begin
			dim = 8'd1;
		end else if (32'(vec_dim_q) > MAX_DIM) begin
			dim = mvms_pkg::DIM_W'(MAX_DIM);
		end else begin
			dim = vec_dim_q;
		end
		if (query_count_q == '0) begin
			qc = 6'd1;
		end else if (32'(query_count_q) > MAX_QUERY_TOKENS) begin
			qc = mvms_pkg::COUNT_W'(MAX_QUERY_TOKENS);
		end else begin
			qc = query_count_q;
		end
	end

	mvms_ctrl #(.MAX_QUERY_TOKENS(MAX_QUERY_TOKENS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_data.cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.qc        (qc),
		.st        (st),
		.cmd       (cmd),
		.cnt       (cnt)
	);

	mvms_dp #(.MAX_DIM(MAX_DIM), .MAX_QUERY_TOKENS(MAX_QUERY_TOKENS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cnt      (cnt),
		.dim      (dim),
		.qc       (qc),
		.in_data  (in_data),
		.st       (st),
		.out_data (out_data)
	);

endmodule

[design/mvms_checker.sv]
// Port-level checks for the MaxSim scorer, bound to the top level.
module mvms_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input mvms_pkg::in_item_t         in_data,
	input logic                       out_valid,
	input logic                       out_ready,
	input mvms_pkg::out_item_t        out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != mvms_pkg::ERR_OK |-> out_data.score == '0)
		else $error("errored result carries a non-zero score");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error_code == mvms_pkg::ERR_OK
			|| out_data.error_code == mvms_pkg::ERR_MID_TOKEN
			|| out_data.error_code == mvms_pkg::ERR_INCOMPLETE)
		else $error("undefined error code");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.cmd == mvms_pkg::CMD_LOAD |=> !$rose(out_valid))
		else $error("query load beat produced a result");

endmodule

bind multivector_maxsim_score mvms_checker u_chk (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the MaxSim scorer: queued driver, monitor and score predictor.
module testbench;
	import mvms_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_DIM * DEF_MAX_QUERY_TOKENS;
	localparam longint ACC_HI   = (64'sd1 <<< 38) - 1;
	localparam longint ACC_LO   = -ACC_HI - 1;
	localparam longint SCORE_HI = (64'sd1 <<< 47) - 1;
	localparam longint SCORE_LO = -SCORE_HI - 1;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE       = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_VEC_DIM;
	logic [DIM_W-1:0] cfg_data = '0;

	multivector_maxsim_score dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	in_item_t pending_beats[$];
	out_item_t expected_scores[$];
	int snd_idle = 0;
	int rcv_idle = 0;
	int fails = 0;
	int stall_cycles = 0;
	bit in_fire = 1'b0;

	// predictor state
	logic [DIM_W-1:0] vd_reg = 8'd128;
	logic [COUNT_W-1:0] qc_reg = 6'd1;
	logic signed [VALUE_BITS-1:0] qstore [STORE_DEPTH];
	int fill = 0;
	bit closed = 1'b0;
	longint dot [DEF_MAX_QUERY_TOKENS];
	longint best [DEF_MAX_QUERY_TOKENS];
	int eidx = 0;
	bit seen = 1'b0;

	// stimulus-side view of the store: loads fill upward from entry 0, so it is a prefix
	int gen_fill = 0;
	bit gen_closed = 1'b0;
	int gen_hi = 0;
	int gd = 128;
	int gc = 1;

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int eff(int raw, int top);
		return raw == 0 ? 1 : (raw > top ? top : raw);
	endfunction

	function automatic void clear_doc();
		for (int q = 0; q < DEF_MAX_QUERY_TOKENS; q++) begin
			dot[q] = 0;
			best[q] = ACC_LO;
		end
		eidx = 0;
		seen = 1'b0;
	endfunction

	function automatic void score_beat(in_item_t it);
		int d;
		int c;
		longint x;
		longint sum;
		out_item_t r;
		d = eff(vd_reg, DEF_MAX_DIM);
		c = eff(qc_reg, DEF_MAX_QUERY_TOKENS);
		x = it.elem_value;
		if (it.cmd == CMD_LOAD) begin
			if (closed) begin
				fill = 0;
				closed = 1'b0;
			end
			if (fill < STORE_DEPTH) begin
				qstore[fill] = it.elem_value;
				fill++;
			end
			if (it.last)
				closed = 1'b1;
			clear_doc();
			return;
		end
		for (int q = 0; q < c; q++)
			dot[q] = sat(dot[q] + longint'(qstore[q * d + eidx]) * x, ACC_LO, ACC_HI);
		eidx++;
		if (eidx >= d) begin
			for (int q = 0; q < c; q++) begin
				if (dot[q] > best[q])
					best[q] = dot[q];
				dot[q] = 0;
			end
			eidx = 0;
			seen = 1'b1;
		end
		if (!it.last)
			return;
		sum = 0;
		r.error_code = ERR_OK;
		if (fill < d * c)
			r.error_code = ERR_INCOMPLETE;
		else if (eidx != 0)
			r.error_code = ERR_MID_TOKEN;
		else if (seen)
			for (int q = 0; q < c; q++)
				sum = sat(sum + best[q], SCORE_LO, SCORE_HI);
		r.score = sum[SCORE_W-1:0];
		expected_scores.push_back(r);
		clear_doc();
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		in_fire = in_valid && in_ready;
		if (in_fire)
			score_beat(in_data);
		if (out_valid && out_ready) begin
			if (expected_scores.size() == 0) begin
				fails++;
				$display("%0t: unexpected result, expected none, got score %0d err %0d",
					$time, out_data.score, out_data.error_code);
			end else begin
				want = expected_scores.pop_front();
				if (want.score !== out_data.score || want.error_code !== out_data.error_code) begin
					fails++;
					$display("%0t: mismatch, expected score %0d err %0d, got score %0d err %0d",
						$time, want.score, want.error_code, out_data.score, out_data.error_code);
				end
			end
		end
		if (in_fire || (out_valid && out_ready) || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_beats.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
					in_valid <= 1'b1;
					in_data <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= $urandom_range(0, 99) >= rcv_idle;
		end
	end

	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	task automatic push_beat(logic cmd, logic signed [VALUE_BITS-1:0] v, logic lst);
		in_item_t it;
		it.cmd = cmd;
		it.elem_value = v;
		it.last = lst;
		if (cmd == CMD_LOAD) begin
			if (gen_closed) begin
				gen_fill = 0;
				gen_closed = 1'b0;
			end
			if (gen_fill < STORE_DEPTH)
				gen_fill++;
			if (gen_fill > gen_hi)
				gen_hi = gen_fill;
			if (lst)
				gen_closed = 1'b1;
		end
		pending_beats.push_back(it);
	endtask

	task automatic load_query(int n);
		for (int i = 0; i < n; i++)
			push_beat(CMD_LOAD, pick_value(), i == n - 1);
	endtask

	// n document elements; never reads a store entry that was not written
	task automatic doc_beats(int n, bit close_doc);
		if (gen_hi < gd * gc)
			load_query(gd * gc);
		for (int i = 0; i < n; i++)
			push_beat(CMD_DOC, pick_value(), close_doc && i == n - 1);
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || expected_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [DIM_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == CFG_VEC_DIM)
			vd_reg = v;
		else
			qc_reg = v[COUNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic start_phase(int raw_dim, int raw_qc, int mode);
		drain();
		write_reg(CFG_VEC_DIM, raw_dim[DIM_W-1:0]);
		write_reg(CFG_QUERY_COUNT, raw_qc[DIM_W-1:0]);
		gd = eff(raw_dim[DIM_W-1:0], DEF_MAX_DIM);
		gc = eff(raw_qc[COUNT_W-1:0], DEF_MAX_QUERY_TOKENS);
		snd_idle = mode == 0 ? 9 : (mode == 1 ? 76 : 0);
		rcv_idle = mode == 0 ? 76 : (mode == 1 ? 9 : 0);
		load_query(gd * gc);
	endtask

	task automatic random_sessions(int budget);
		int n;
		int goal;
		goal = pending_beats.size() + budget;
		n = gd * gc;
		while (pending_beats.size() < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: doc_beats(gd * $urandom_range(1, 3), 1'b1);
				4: load_query(n);
				5: begin
					// short reload over older contents, then a document, flagged incomplete if the reload restarted the store
					if (n > 1 && gen_hi >= n) begin
						load_query($urandom_range(1, n - 1));
						doc_beats(gd, 1'b1);
					end
				end
				6: if (gd > 1) doc_beats(gd * $urandom_range(0, 2) + $urandom_range(1, gd - 1), 1'b1);
				7: begin
					// document abandoned by a fresh query load
					doc_beats($urandom_range(1, 2 * gd), 1'b0);
					load_query(n);
				end
				8: load_query(n + $urandom_range(1, 3));
				default: begin
					for (int i = 0; i < 4; i++)
						if ($urandom_range(0, 1) && gen_hi >= n)
							push_beat(CMD_DOC, pick_value(), $urandom_range(0, 3) == 0);
						else
							push_beat(CMD_LOAD, pick_value(), $urandom_range(0, 3) == 0);
				end
			endcase
		end
	endtask

	initial begin
		clear_doc();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, both errors, abandon, reload
		start_phase(3, 2, 0);
		doc_beats(3, 1'b0);
		push_beat(CMD_DOC, 16'sh8000, 1'b0);
		push_beat(CMD_DOC, 16'sh7fff, 1'b0);
		push_beat(CMD_DOC, 16'sh8000, 1'b1);
		doc_beats(4, 1'b1);
		doc_beats(2, 1'b0);
		load_query(2);
		doc_beats(3, 1'b1);
		load_query(6);
		doc_beats(1, 1'b1);
		random_sessions(70);

		start_phase(0, 0, 0);
		random_sessions(80);
		start_phase(7, 3, 0);
		random_sessions(80);

		// both registers above their range: dimension and token count clamp
		start_phase(255, 1, 1);
		doc_beats(128, 1'b1);
		start_phase(1, 63, 1);
		random_sessions(60);

		start_phase(5, 6, 2);
		random_sessions(80);
		start_phase(4, 4, 2);
		random_sessions(80);

		drain();
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[multivector_maxsim_score.f]
design/mvms_pkg.sv
design/mvms_ram.sv
design/mvms_ctrl.sv
design/mvms_dp.sv
design/multivector_maxsim_score.sv
design/mvms_checker.sv
tb/sv/testbench.sv
